[sv/renc_pkg.sv]
// Shared types, constants and the quadrature table for the rotary encoder block.
package renc_pkg;

    localparam int CFG_W = 12;
    localparam int CFG_IDX_W = 2;
    localparam int STEPS_PER_DETENT_DEF = 4;
    localparam int TIMER_WIDTH_DEF = 12;

    localparam logic [CFG_W-1:0] DEBOUNCE_MS_RST = 12'd35;
    localparam logic [CFG_W-1:0] LONG_PRESS_MS_RST = 12'd850;
    localparam logic LONG_PRESS_MODE_RST = 1'b1;

    localparam logic [1:0] AB_IDLE = 2'b11;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MODE = 2'd2;

    // Step delta for each transition, indexed by {previous AB, current AB}.
    localparam logic signed [1:0] QUAD_DELTA [16] = '{
        2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
        -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
    };

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic             long_press_mode;
    } renc_cfg_t;

    typedef struct packed {
        logic step_left;
        logic step_right;
        logic click;
        logic long_press;
        logic button_level;
    } renc_result_t;

endpackage

[sv/renc_core.sv]
// Encoder step accumulation and button debounce state, updated once per accepted sample.
module renc_core #(
    parameter int STEPS_PER_DETENT = renc_pkg::STEPS_PER_DETENT_DEF,
    parameter int TIMER_WIDTH = renc_pkg::TIMER_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   sample_en,
    input  logic                   pin_a,
    input  logic                   pin_b,
    input  logic                   button_raw,
    input  logic                   ms_tick,
    input  renc_pkg::renc_cfg_t    cfg,
    output renc_pkg::renc_result_t result
);

    localparam int ACC_W = $clog2(STEPS_PER_DETENT + 1) + 1;
    localparam int CMP_W = (TIMER_WIDTH > renc_pkg::CFG_W) ? TIMER_WIDTH : renc_pkg::CFG_W;
    localparam logic signed [ACC_W-1:0] DETENT = ACC_W'(STEPS_PER_DETENT);
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

    logic [1:0]              prev_ab_reg, prev_ab_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    last_raw_reg, last_raw_next;
    logic                    stable_reg, stable_next;
    logic [TIMER_WIDTH-1:0]  elapsed_reg, elapsed_next;
    logic                    long_fired_reg, long_fired_next;

    logic [1:0]              ab;
    logic                    ab_changed;
    logic signed [ACC_W-1:0] acc_sum;
    logic                    go_left, go_right;
    logic [CMP_W-1:0]        elapsed_ext;
    logic                    debounced;
    logic                    fired_after_press;
    logic                    long_hit;

    always_comb begin
        ab = {pin_a, pin_b};
        ab_changed = (ab != prev_ab_reg);
        acc_sum = acc_reg + ACC_W'(renc_pkg::QUAD_DELTA[{prev_ab_reg, ab}]);
        go_left = ab_changed && (acc_sum <= -DETENT);
        go_right = ab_changed && (acc_sum >= DETENT);
        prev_ab_next = ab;
        if (!ab_changed) begin
            acc_next = acc_reg;
        end else if (go_left || go_right) begin
            acc_next = '0;
        end else begin
            acc_next = acc_sum;
        end

        // A raw change restarts the hold timer; that sample's tick is dropped.
        last_raw_next = button_raw;
        if (button_raw != last_raw_reg) begin
            elapsed_next = '0;
        end else if (ms_tick && (elapsed_reg != TIMER_MAX)) begin
            elapsed_next = elapsed_reg + TIMER_WIDTH'(1);
        end else begin
            elapsed_next = elapsed_reg;
        end
        elapsed_ext = CMP_W'(elapsed_next);

        debounced = (button_raw != stable_reg) &&
                    (elapsed_ext >= CMP_W'(cfg.debounce_ms));
        stable_next = debounced ? button_raw : stable_reg;
        fired_after_press = (debounced && !button_raw) ? 1'b0 : long_fired_reg;

        long_hit = cfg.long_press_mode && !stable_next && !fired_after_press &&
                   (elapsed_ext >= CMP_W'(cfg.long_press_ms));
        long_fired_next = long_hit | fired_after_press;

        result.step_left = go_left;
        result.step_right = go_right;
        if (!debounced) begin
            result.click = 1'b0;
        end else if (!button_raw) begin
            result.click = !cfg.long_press_mode;
        end else begin
            result.click = cfg.long_press_mode && !long_fired_reg;
        end
        result.long_press = long_hit;
        result.button_level = stable_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_ab_reg <= renc_pkg::AB_IDLE;
            acc_reg <= '0;
            last_raw_reg <= 1'b1;
            stable_reg <= 1'b1;
            elapsed_reg <= '0;
            long_fired_reg <= 1'b0;
        end else if (sample_en) begin
            prev_ab_reg <= prev_ab_next;
            acc_reg <= acc_next;
            last_raw_reg <= last_raw_next;
            stable_reg <= stable_next;
            elapsed_reg <= elapsed_next;
            long_fired_reg <= long_fired_next;
        end
    end

endmodule

[sv/rotary_encoder_with_button.sv]
// Top level of the rotary encoder and push button decoder with stream ports.
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_tvalid/s_tready  s_tdata[7:0]: pin_a, pin_b, button_raw, ms_tick
//  m_        out        m_tvalid/m_tready  m_tdata[7:0]: step_left, step_right, click,
//                                          long_press, button_level
//  cfg_      in         cfg_we             cfg_addr, cfg_wdata[11:0]
//
// One sample is taken per clock while s_tready is high; each transaction gives one result.
// The state update is a single pass from the state registers into the result register.
// A two-entry output buffer keeps s_tready independent of m_tready, so a stall on the
// result side costs nothing until both entries are full.
// aresetn is synchronous and active low; the registers return to 35 ms, 850 ms, mode 1.
module rotary_encoder_with_button #(
    parameter int STEPS_PER_DETENT = renc_pkg::STEPS_PER_DETENT_DEF,
    parameter int TIMER_WIDTH = renc_pkg::TIMER_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [0] pin_a, [1] pin_b, [2] button_raw, [3] ms_tick, [7:4] zero
    input  logic [7:0]                     s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] step_left, [1] step_right, [2] click, [3] long_press, [4] button_level, [7:5] zero
    output logic [7:0]                     m_tdata,
    input  logic                           cfg_we,
    input  logic [renc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [renc_pkg::CFG_W-1:0]     cfg_wdata
);

    renc_pkg::renc_cfg_t    cfg_reg;
    renc_pkg::renc_result_t result;
    logic                   accept;
    logic [7:0]             result_data;
    logic [7:0]             main_data_reg, skid_data_reg;
    logic                   main_valid_reg, skid_valid_reg;

    assign s_tready = !skid_valid_reg;
    assign accept = s_tvalid && s_tready;
    assign m_tvalid = main_valid_reg;
    assign m_tdata = main_data_reg;

    assign result_data = {3'b000, result.button_level, result.long_press, result.click,
                          result.step_right, result.step_left};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms <= renc_pkg::DEBOUNCE_MS_RST;
            cfg_reg.long_press_ms <= renc_pkg::LONG_PRESS_MS_RST;
            cfg_reg.long_press_mode <= renc_pkg::LONG_PRESS_MODE_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                renc_pkg::REG_DEBOUNCE_MS: cfg_reg.debounce_ms <= cfg_wdata;
                renc_pkg::REG_LONG_PRESS_MS: cfg_reg.long_press_ms <= cfg_wdata;
                renc_pkg::REG_LONG_PRESS_MODE: cfg_reg.long_press_mode <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    renc_core #(
        .STEPS_PER_DETENT(STEPS_PER_DETENT),
        .TIMER_WIDTH(TIMER_WIDTH)
    ) u_core (
        .aclk(aclk),
        .aresetn(aresetn),
        .sample_en(accept),
        .pin_a(s_tdata[0]),
        .pin_b(s_tdata[1]),
        .button_raw(s_tdata[2]),
        .ms_tick(s_tdata[3]),
        .cfg(cfg_reg),
        .result(result)
    );

    // The skid entry only fills when the output is held and a new transaction arrives.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (accept) begin
            if (main_valid_reg && !m_tready) begin
                skid_valid_reg <= 1'b1;
                skid_data_reg <= result_data;
            end else begin
                main_valid_reg <= 1'b1;
                main_data_reg <= result_data;
            end
        end else if (m_tready) begin
            if (skid_valid_reg) begin
                main_data_reg <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[sv/renc_checker.sv]
// Port-level checks for the rotary encoder block and the bind that attaches them.
module renc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // A held result must not change until its transaction completes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Input backpressure only happens while a result is waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("left and right detent in one result");

    // Long press needs mode 1 and a held button; in mode 1 a click comes only on a release with no long press.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[2] && m_tdata[3]))
        else $error("click and long press in one result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> !m_tdata[4] && m_tdata[7:5] == 3'b000)
        else $error("long press with released level or nonzero padding");

endmodule

bind rotary_encoder_with_button renc_checker u_renc_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
);

[sim/rotary_encoder_with_button_test.sv]
// Self-checking testbench for the rotary encoder and push button decoder.
module rotary_encoder_with_button_test;

    localparam int DETENT_STEPS = 4;
    // Step for each {previous AB, current AB} transition; double-bit jumps count as zero.
    localparam int TURN_DELTA [16] = '{
        0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0
    };
    // Encoder positions in rotation order.
    localparam logic [1:0] GRAY_POS [4] = '{2'b00, 2'b10, 2'b11, 2'b01};

    typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                       kind;
        logic [renc_pkg::CFG_IDX_W-1:0]  reg_idx;
        logic [renc_pkg::CFG_W-1:0]      reg_val;
        logic                            pin_a;
        logic                            pin_b;
        logic                            button_raw;
        logic                            ms_tick;
        logic                            typed;
        renc_pkg::renc_result_t          want;
    } row_t;

    // want is {step_left, step_right, click, long_press, button_level}.
    localparam row_t DIRECTED [25] = '{
        '{ROW_SAMPLE, renc_pkg::REG_DEBOUNCE_MS, 12'd0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 5'b00001},
        '{ROW_SAMPLE, renc_pkg::REG_DEBOUNCE_MS, 12'd0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 5'b00000},
        '{ROW_SAMPLE, renc_pkg::REG_DEBOUNCE_MS, 12'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 5'b00000},
        '{ROW_SAMPLE, renc_pkg::REG_DEBOUNCE_MS, 12'd0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 5'b00000},
        '{ROW_SAMPLE, renc_pkg::REG_DEBOUNCE_MS, 12'd0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 5'b01001},
        '{ROW_SAMPLE, renc_pkg::REG_DEBOUNCE_MS, 12'd0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 5'b00000},
        '{ROW_SAMPLE, renc_pkg::REG_DEBOUNCE_MS, 12'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 5'b00000},
        '{ROW_SAMPLE, renc_pkg::REG_DEBOUNCE_MS, 12'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 5'b00000},
        '{ROW_SAMPLE, renc_pkg::REG_DEBOUNCE_MS, 12'd0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 5'b10001},
        '{ROW_SAMPLE, renc_pkg::REG_DEBOUNCE_MS, 12'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 5'b00000},
        '{ROW_SAMPLE, renc_pkg::REG_DEBOUNCE_MS, 12'd0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 5'b00000},
        '{ROW_CFG, renc_pkg::REG_DEBOUNCE_MS, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 5'b00000},
        '{ROW_CFG, renc_pkg::REG_LONG_PRESS_MS, 12'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 5'b00000},
        '{ROW_SAMPLE, renc_pkg::REG_DEBOUNCE_MS, 12'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 5'b00000},
        '{ROW_SAMPLE, renc_pkg::REG_DEBOUNCE_MS, 12'd0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 5'b00010},
        '{ROW_SAMPLE, renc_pkg::REG_DEBOUNCE_MS, 12'd0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 5'b00000},
        '{ROW_SAMPLE, renc_pkg::REG_DEBOUNCE_MS, 12'd0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 5'b00001},
        '{ROW_SAMPLE, renc_pkg::REG_DEBOUNCE_MS, 12'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 5'b00000},
        '{ROW_SAMPLE, renc_pkg::REG_DEBOUNCE_MS, 12'd0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 5'b00101},
        '{ROW_CFG, renc_pkg::REG_LONG_PRESS_MODE, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 5'b00000},
        '{ROW_SAMPLE, renc_pkg::REG_DEBOUNCE_MS, 12'd0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 5'b00100},
        '{ROW_SAMPLE, renc_pkg::REG_DEBOUNCE_MS, 12'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 5'b00001},
        '{ROW_SAMPLE, renc_pkg::REG_DEBOUNCE_MS, 12'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 5'b00100},
        '{ROW_CFG, renc_pkg::REG_LONG_PRESS_MODE, 12'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 5'b00000},
        '{ROW_SAMPLE, renc_pkg::REG_DEBOUNCE_MS, 12'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 5'b00101}
    };

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata = 8'h00;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [7:0]                     m_tdata;
    logic                           cfg_we = 1'b0;
    logic [renc_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
    logic [renc_pkg::CFG_W-1:0]     cfg_wdata = '0;

    // Predictor state, starting from the reset values.
    logic [1:0]                 enc_prev_ab = 2'b11;
    int                         enc_acc = 0;
    logic                       key_last_raw = 1'b1;
    logic                       key_stable = 1'b1;
    logic [11:0]                key_ms = '0;
    logic                       key_long_done = 1'b0;
    logic [renc_pkg::CFG_W-1:0] reg_debounce = 12'd35;
    logic [renc_pkg::CFG_W-1:0] reg_long = 12'd850;
    logic                       reg_mode = 1'b1;

    // Stimulus generator state.
    int   gen_pos = 2;
    int   gen_dir = 1;
    logic gen_btn = 1'b1;
    int   gen_btn_left = 0;
    int   gen_btn_age = 0;

    renc_pkg::renc_result_t awaited_events [$];
    int                     errors = 0;
    int                     results_seen = 0;
    int                     send_burst = 0;
    bit                     sender_no_idle = 1'b0;

    rotary_encoder_with_button DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("rotary_encoder_with_button_test: done, errors");
        $finish;
    end

    function automatic renc_pkg::renc_result_t decode_sample(input logic a, b, raw, tick);
        renc_pkg::renc_result_t res;
        logic [1:0]             ab;
        res = '0;
        ab = {a, b};
        if (ab != enc_prev_ab) begin
            enc_acc = enc_acc + TURN_DELTA[{enc_prev_ab, ab}];
            enc_prev_ab = ab;
            if (enc_acc <= -DETENT_STEPS) begin
                enc_acc = 0;
                res.step_left = 1'b1;
            end else if (enc_acc >= DETENT_STEPS) begin
                enc_acc = 0;
                res.step_right = 1'b1;
            end
        end
        // A raw change restarts the millisecond count and swallows this sample's tick.
        if (raw != key_last_raw) begin
            key_last_raw = raw;
            key_ms = '0;
        end else if (tick && key_ms != '1) begin
            key_ms = key_ms + 12'd1;
        end
        if (raw != key_stable && key_ms >= reg_debounce) begin
            key_stable = raw;
            if (!key_stable) begin
                key_long_done = 1'b0;
                if (!reg_mode) res.click = 1'b1;
            end else if (reg_mode && !key_long_done) begin
                res.click = 1'b1;
            end
        end
        if (reg_mode && !key_stable && !key_long_done && key_ms >= reg_long) begin
            key_long_done = 1'b1;
            res.long_press = 1'b1;
        end
        res.button_level = key_stable;
        return res;
    endfunction

    task automatic check_bit(input string name, input logic want, input logic got);
        if (got !== want) begin
            $error("%s: expected %0b, got %0b", name, want, got);
            errors++;
        end
    endtask

    task automatic check_result(input renc_pkg::renc_result_t want, input logic [7:0] got);
        check_bit("step_left", want.step_left, got[0]);
        check_bit("step_right", want.step_right, got[1]);
        check_bit("click", want.click, got[2]);
        check_bit("long_press", want.long_press, got[3]);
        check_bit("button_level", want.button_level, got[4]);
    endtask

    task automatic send_sample(input logic a, b, raw, tick, input logic typed,
                               input renc_pkg::renc_result_t want);
        int                     gap;
        renc_pkg::renc_result_t predicted;
        if (sender_no_idle) begin
            gap = 0;
        end else if (send_burst > 0) begin
            send_burst--;
            gap = 0;
        end else if ($urandom_range(0, 19) == 0) begin
            send_burst = $urandom_range(10, 40);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 14);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0000, tick, raw, b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = decode_sample(a, b, raw, tick);
        awaited_events.push_back(typed ? want : predicted);
    endtask

    task automatic drain_events();
        s_tvalid <= 1'b0;
        while (awaited_events.size() != 0) @(posedge aclk);
    endtask

    task automatic write_setting(input logic [renc_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [renc_pkg::CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            renc_pkg::REG_DEBOUNCE_MS:     reg_debounce = val;
            renc_pkg::REG_LONG_PRESS_MS:   reg_long = val;
            renc_pkg::REG_LONG_PRESS_MODE: reg_mode = val[0];
            default: ;
        endcase
    endtask

    // Mostly steady rotation with held button levels; some bounce, reversals and jumps.
    task automatic next_random_sample(input int hold_max, output logic a, b, raw, tick);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            gen_pos = $urandom_range(0, 3);
        else if (r < 10)
            gen_pos = (gen_pos - gen_dir) & 3;
        else if (r < 45)
            gen_pos = (gen_pos + gen_dir) & 3;
        if ($urandom_range(0, 49) == 0) gen_dir = -gen_dir;
        {a, b} = GRAY_POS[gen_pos];
        if (gen_btn_left == 0) begin
            gen_btn = ~gen_btn;
            gen_btn_left = $urandom_range(1, hold_max);
            gen_btn_age = 0;
        end
        gen_btn_left--;
        raw = gen_btn;
        // Contact bounce only right after a level change.
        if (gen_btn_age < 4 && $urandom_range(0, 2) == 0) raw = ~raw;
        gen_btn_age++;
        tick = ($urandom_range(0, 3) != 0);
    endtask

    task automatic run_phase(input logic [renc_pkg::CFG_W-1:0] deb, lng, input logic mode,
                             input int count, hold_max);
        logic a, b, raw, tick;
        drain_events();
        write_setting(renc_pkg::REG_DEBOUNCE_MS, deb);
        write_setting(renc_pkg::REG_LONG_PRESS_MS, lng);
        write_setting(renc_pkg::REG_LONG_PRESS_MODE, {{(renc_pkg::CFG_W-1){1'b0}}, mode});
        repeat (count) begin
            next_random_sample(hold_max, a, b, raw, tick);
            send_sample(a, b, raw, tick, 1'b0, '0);
        end
    endtask

    initial begin : result_sink
        int                     stall;
        int                     burst;
        renc_pkg::renc_result_t want;
        burst = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            // One long hold-off lets the output buffer fill so that s_tready drops.
            if (results_seen == 300) begin
                stall = 80;
            end else if (burst > 0) begin
                burst--;
                stall = 0;
            end else if ($urandom_range(0, 19) == 0) begin
                burst = $urandom_range(10, 40);
                stall = 0;
            end else begin
                stall = $urandom_range(0, 14);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            results_seen++;
            if (awaited_events.size() == 0) begin
                $error("result transaction with no sample pending: m_tdata=%02h", m_tdata);
                errors++;
            end else begin
                want = awaited_events.pop_front();
                check_result(want, m_tdata);
            end
        end
    end

    initial begin : stimulus
        int   i;
        logic a, b, raw, tick;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < 25; i++) begin
            if (DIRECTED[i].kind == ROW_CFG) begin
                drain_events();
                write_setting(DIRECTED[i].reg_idx, DIRECTED[i].reg_val);
            end else begin
                send_sample(DIRECTED[i].pin_a, DIRECTED[i].pin_b, DIRECTED[i].button_raw,
                            DIRECTED[i].ms_tick, DIRECTED[i].typed, DIRECTED[i].want);
            end
        end

        run_phase(12'd35, 12'd850, 1'b1, 200, 120);
        run_phase(12'd0, 12'd1, 1'b0, 100, 10);
        run_phase(12'd0, 12'd1, 1'b1, 100, 10);

        // Largest thresholds: a long held press that never reaches them.
        drain_events();
        write_setting(renc_pkg::REG_DEBOUNCE_MS, 12'd4095);
        write_setting(renc_pkg::REG_LONG_PRESS_MS, 12'd4095);
        write_setting(renc_pkg::REG_LONG_PRESS_MODE, 12'd1);
        sender_no_idle = 1'b1;
        repeat (150) begin
            next_random_sample(20, a, b, raw, tick);
            send_sample(a, b, 1'b0, 1'b1, 1'b0, '0);
        end
        sender_no_idle = 1'b0;

        run_phase(12'd0, 12'd4095, 1'b1, 60, 20);
        run_phase(12'd4095, 12'd1, 1'b0, 40, 20);
        repeat (4) begin
            run_phase(12'($urandom_range(0, 8)), 12'($urandom_range(1, 24)),
                      1'($urandom_range(0, 1)), 70, 30);
        end

        drain_events();
        repeat (10) @(posedge aclk);
        if (errors == 0)
            $display("rotary_encoder_with_button_test: done, clean");
        else
            $display("rotary_encoder_with_button_test: done, errors");
        $finish;
    end

endmodule

[files.f]
sv/renc_pkg.sv
sv/renc_core.sv
sv/rotary_encoder_with_button.sv
sv/renc_checker.sv
sim/rotary_encoder_with_button_test.sv
